// File: sv/tfb_pkg.sv
// Shared constants, register indexes and the request entry type of the telemetry framer.
package tfb_pkg;

   localparam int MAX_PAYLOAD_WORDS = 10;
   localparam int MAX_PAYLOAD_BYTES = 2 * MAX_PAYLOAD_WORDS;
   localparam int MAX_FRAME_BYTES   = MAX_PAYLOAD_BYTES + 6;
   localparam int BYTE_W            = 8;
   localparam int WORD_W            = 16;
   localparam int LEN_W             = 5;
   localparam int POS_W             = 5;
   localparam int CSR_INDEX_W       = 8;
   localparam int QUEUE_DEPTH       = 2;
   localparam int QPTR_W            = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W            = $clog2(QUEUE_DEPTH + 1);

   localparam logic [BYTE_W-1:0] RESET_HEADER  = 8'hAA;
   localparam logic [BYTE_W-1:0] RESET_ADDRESS = 8'hFF;
   localparam logic [BYTE_W-1:0] SYNC_ID       = 8'hFB;

   // Register indexes of the configuration port
   localparam logic [CSR_INDEX_W-1:0] REG_HEADER  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_ADDRESS = CSR_INDEX_W'(1);

   typedef struct packed {
      logic [BYTE_W-1:0]                   frame_id;
      logic [LEN_W-1:0]                    payload_length;
      logic [MAX_PAYLOAD_BYTES*BYTE_W-1:0] payload;
   } tfb_entry_type;

endpackage

// File: sv/tfb_front.sv
// Request intake: length saturation, payload packing and a two-entry request queue.
module tfb_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [7:0]                 req_frame_id,
   input  logic [4:0]                 req_payload_length,
   input  logic signed [15:0]         req_word_0,
   input  logic signed [15:0]         req_word_1,
   input  logic signed [15:0]         req_word_2,
   input  logic signed [15:0]         req_word_3,
   input  logic signed [15:0]         req_word_4,
   input  logic signed [15:0]         req_word_5,
   input  logic signed [15:0]         req_word_6,
   input  logic signed [15:0]         req_word_7,
   input  logic signed [15:0]         req_word_8,
   input  logic signed [15:0]         req_word_9,
   output logic                       q_valid,
   output tfb_pkg::tfb_entry_type     q_entry,
   input  logic                       q_pop
);
   import tfb_pkg::*;

   tfb_entry_type            entry_ff [QUEUE_DEPTH];
   tfb_entry_type            new_entry;
   logic [QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]        count_ff, count_in;
   logic                     push;
   logic [WORD_W-1:0]        words [MAX_PAYLOAD_WORDS];

   assign words[0] = req_word_0;
   assign words[1] = req_word_1;
   assign words[2] = req_word_2;
   assign words[3] = req_word_3;
   assign words[4] = req_word_4;
   assign words[5] = req_word_5;
   assign words[6] = req_word_6;
   assign words[7] = req_word_7;
   assign words[8] = req_word_8;
   assign words[9] = req_word_9;

   assign req_stall = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != '0);
   assign q_entry   = entry_ff[rd_ptr_ff];

   // pack words low byte first; overlong lengths clamp to the full payload
   always_comb begin
      new_entry.frame_id = req_frame_id;
      if (req_payload_length > LEN_W'(MAX_PAYLOAD_BYTES)) begin
         new_entry.payload_length = LEN_W'(MAX_PAYLOAD_BYTES);
      end else begin
         new_entry.payload_length = req_payload_length;
      end
      for (int w = 0; w < MAX_PAYLOAD_WORDS; w++) begin
         new_entry.payload[w*WORD_W +: WORD_W] = words[w];
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_entry;
      end
   end

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("pop from empty request queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("request queue overfilled");

endmodule

// File: sv/tfb_back.sv
// Frame serializer: walks one queued request byte by byte and builds both check bytes.
module tfb_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [7:0]             header_byte,
   input  logic [7:0]             address_byte,
   input  logic                   q_valid,
   input  tfb_pkg::tfb_entry_type q_entry,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_frame_byte,
   output logic                   rsp_last_byte
);
   import tfb_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SEND = 2'b10
   } state_type;

   state_type                           state_ff, state_in;
   logic [POS_W-1:0]                    pos_ff, pos_in;
   logic [BYTE_W-1:0]                   sum_ff, sum_in;
   logic [BYTE_W-1:0]                   add_ff, add_in;
   logic [BYTE_W-1:0]                   id_ff, id_in;
   logic [LEN_W-1:0]                    len_ff, len_in;
   logic [MAX_PAYLOAD_BYTES*BYTE_W-1:0] payload_ff, payload_in;
   logic                                out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0]                   out_byte_ff, out_byte_in;
   logic                                out_last_ff, out_last_in;

   logic                                advance;
   logic [BYTE_W-1:0]                   byte_sel;
   logic                                counted;
   logic                                is_last;
   logic                                is_payload;
   logic [POS_W:0]                      payload_end;

   assign rsp_valid      = out_valid_ff;
   assign rsp_frame_byte = out_byte_ff;
   assign rsp_last_byte  = out_last_ff;

   assign advance     = (state_ff == ST_SEND) && (!out_valid_ff || !rsp_stall);
   assign payload_end = (POS_W+1)'(len_ff) + (POS_W+1)'(4);

   // byte at the current position
   always_comb begin
      byte_sel   = sum_ff;
      counted    = 1'b0;
      is_last    = 1'b0;
      is_payload = 1'b0;
      priority if (pos_ff == POS_W'(0)) begin
         byte_sel = header_byte;
         counted  = 1'b1;
      end else if (pos_ff == POS_W'(1)) begin
         byte_sel = address_byte;
         counted  = 1'b1;
      end else if (pos_ff == POS_W'(2)) begin
         byte_sel = id_ff;
         counted  = 1'b1;
      end else if (pos_ff == POS_W'(3)) begin
         byte_sel = BYTE_W'(len_ff);
         counted  = 1'b1;
      end else if ({1'b0, pos_ff} < payload_end) begin
         byte_sel   = payload_ff[BYTE_W-1:0];
         counted    = 1'b1;
         is_payload = 1'b1;
      end else if ({1'b0, pos_ff} == payload_end) begin
         byte_sel = sum_ff;
      end else begin
         byte_sel = add_ff;
         is_last  = 1'b1;
      end
   end

   always_comb begin
      state_in   = state_ff;
      pos_in     = pos_ff;
      sum_in     = sum_ff;
      add_in     = add_ff;
      id_in      = id_ff;
      len_in     = len_ff;
      payload_in = payload_ff;
      q_pop      = 1'b0;
      out_byte_in = out_byte_ff;
      out_last_in = out_last_ff;
      out_valid_in = out_valid_ff && rsp_stall;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
            end
         end
         ST_SEND: begin
            if (advance) begin
               out_valid_in = 1'b1;
               out_byte_in  = byte_sel;
               out_last_in  = is_last;
               pos_in       = pos_ff + 1'b1;
               if (counted) begin
                  sum_in = sum_ff + byte_sel;
                  add_in = add_ff + sum_ff + byte_sel;
               end
               if (is_payload) begin
                  payload_in = payload_ff >> BYTE_W;
               end
               if (is_last) begin
                  pos_in   = '0;
                  state_in = ST_IDLE;
                  q_pop    = q_valid;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // next frame starts right behind the add check byte
      if (q_pop) begin
         state_in   = ST_SEND;
         pos_in     = '0;
         sum_in     = '0;
         add_in     = '0;
         id_in      = q_entry.frame_id;
         len_in     = q_entry.payload_length;
         payload_in = q_entry.payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         sum_ff       <= '0;
         add_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         sum_ff       <= sum_in;
         add_ff       <= add_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff       <= id_in;
      len_ff      <= len_in;
      payload_ff  <= payload_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_W'(MAX_FRAME_BYTES - 1))
      else $error("frame position past end of longest frame");

   a_idle_pos: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (pos_ff == '0))
      else $error("position not rewound while idle");

   a_pop_starts: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (state_ff == ST_SEND) && (pos_ff == '0) && (sum_ff == '0))
      else $error("popped request did not start a fresh frame");

endmodule

// File: sv/telemetry_frame_builder_core.sv
// Top level of the telemetry framer: config registers, request queue and byte serializer.
// First byte of a frame passes the queue entry, the serializer state and its output byte register.
// One frame byte per cycle while rsp_stall is low; a frame of length L has L + 6 bytes
//   (6 to 26); the rate is set by the serializer's single output byte register.
// Queued frames follow each other with no gap; up to two requests wait in the queue.
// Reset (synchronous, active high) empties the queue, idles the serializer and
//   restores header 0xAA and address 0xFF.
module telemetry_frame_builder_core (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [7:0]                           req_frame_id,
   input  logic [4:0]                           req_payload_length,
   input  logic signed [15:0]                   req_word_0,
   input  logic signed [15:0]                   req_word_1,
   input  logic signed [15:0]                   req_word_2,
   input  logic signed [15:0]                   req_word_3,
   input  logic signed [15:0]                   req_word_4,
   input  logic signed [15:0]                   req_word_5,
   input  logic signed [15:0]                   req_word_6,
   input  logic signed [15:0]                   req_word_7,
   input  logic signed [15:0]                   req_word_8,
   input  logic signed [15:0]                   req_word_9,
   // frame byte channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [7:0]                           rsp_frame_byte,
   output logic                                 rsp_last_byte,
   // register write channel
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [tfb_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [7:0]                           csr_data
);
   import tfb_pkg::*;

   logic [BYTE_W-1:0] header_ff, header_in;
   logic [BYTE_W-1:0] address_ff, address_in;
   logic              csr_write;

   logic              q_valid;
   logic              q_pop;
   tfb_entry_type     q_entry;

   // register writes are always accepted and take effect in the next cycle; unknown indexes drop
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      header_in  = header_ff;
      address_in = address_ff;
      if (csr_write) begin
         if (csr_index == REG_HEADER) begin
            header_in = csr_data;
         end else if (csr_index == REG_ADDRESS) begin
            address_in = csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff  <= RESET_HEADER;
         address_ff <= RESET_ADDRESS;
      end else begin
         header_ff  <= header_in;
         address_ff <= address_in;
      end
   end

   // front: clamps length, packs payload, queues the request.
   // A sync frame (id 0xFB, length 0) needs no special path.
   tfb_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_frame_id       (req_frame_id),
      .req_payload_length (req_payload_length),
      .req_word_0         (req_word_0),
      .req_word_1         (req_word_1),
      .req_word_2         (req_word_2),
      .req_word_3         (req_word_3),
      .req_word_4         (req_word_4),
      .req_word_5         (req_word_5),
      .req_word_6         (req_word_6),
      .req_word_7         (req_word_7),
      .req_word_8         (req_word_8),
      .req_word_9         (req_word_9),
      .q_valid            (q_valid),
      .q_entry            (q_entry),
      .q_pop              (q_pop)
   );

   // back: header, address, id, length, payload, sum check, add check
   tfb_back u_back (
      .clock          (clock),
      .reset          (reset),
      .header_byte    (header_ff),
      .address_byte   (address_ff),
      .q_valid        (q_valid),
      .q_entry        (q_entry),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_last_byte  (rsp_last_byte)
   );

endmodule
